// ----- design/modular_exponentiation_32_assert.svh -----
// assertion macros for the modular exponentiation block
// the first form checks an implication in the same cycle, the second in the following cycle
`ifndef MODULAR_EXPONENTIATION_32_ASSERT_SVH
`define MODULAR_EXPONENTIATION_32_ASSERT_SVH
`ifndef SYNTHESIS
`define MEXP_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`define MEXP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MEXP_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg)
`define MEXP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// ----- design/mexp_pkg.sv -----
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned CNT_W  = $clog2(PROD_W);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PROD_W-1:0] prod_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_B,
    ST_WAIT_B,
    ST_CHECK,
    ST_MUL_ACC,
    ST_DIV_ACC,
    ST_WAIT_ACC,
    ST_MUL_SQ,
    ST_DIV_SQ,
    ST_WAIT_SQ,
    ST_DONE
  } mexp_state_t;

endpackage

// ----- design/mexp_rem.sv -----
`timescale 1ns / 1ps

// bit-serial restoring remainder: 64-bit dividend mod 32-bit divisor
module mexp_rem (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mexp_pkg::prod_t dividend,
  input  mexp_pkg::word_t divisor,
  output logic            done,
  output mexp_pkg::word_t remainder
);

  mexp_pkg::prod_t             dvd;
  logic [mexp_pkg::CNT_W-1:0]  cnt;
  logic                        busy;
  logic [mexp_pkg::WORD_W:0]   trial;
  logic [mexp_pkg::WORD_W:0]   trial_sub;

  // shift in the next dividend bit, subtract if it fits
  assign trial     = {remainder, dvd[mexp_pkg::PROD_W-1]};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      remainder <= '0;
      cnt       <= mexp_pkg::CNT_W'(mexp_pkg::PROD_W - 1);
    end else if (busy) begin
      dvd <= {dvd[mexp_pkg::PROD_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (trial >= {1'b0, divisor}) begin
        remainder <= trial_sub[mexp_pkg::WORD_W-1:0];
      end else begin
        remainder <= trial[mexp_pkg::WORD_W-1:0];
      end
    end
  end

endmodule

// ----- design/modular_exponentiation_32.sv -----
`timescale 1ns / 1ps

// 32-bit modular exponentiation, residue = base_value ** power mod modulus, by
// right-to-left square-and-multiply. one beat in, one beat out. the block takes
// one item at a time: in_ready is high only while the sequencer is idle. after
// acceptance the base is reduced once, then each exponent bit up to the highest
// set one costs a check and one square plus, when the bit is set, one multiply.
// after a final check and the load of the result, out_valid rises, and in_ready
// is high again in that same cycle. every reduction runs through the shared
// bit-serial remainder unit, which reduces each 64-bit product bit by bit. a
// zero power gives 1 mod modulus; a zero modulus skips the arithmetic and
// returns residue 0 with bad_modulus set. the result sits in an output
// register, so the next beat can be accepted while a finished result still
// waits for out_ready.
module modular_exponentiation_32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] base_value,
  input  logic [31:0] power,
  input  logic [31:0] modulus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] residue,
  output logic        bad_modulus
);

`include "modular_exponentiation_32_assert.svh"

  mexp_pkg::mexp_state_t state, state_next;

  // operands of the item in flight
  mexp_pkg::word_t b_r;
  mexp_pkg::word_t exp_r;
  mexp_pkg::word_t mod_r;
  logic            bad_r;

  // running product and running square, both kept below the modulus
  mexp_pkg::word_t acc;
  mexp_pkg::word_t sq;
  mexp_pkg::prod_t prod;

  // shared multiplier
  mexp_pkg::word_t mul_a;
  mexp_pkg::prod_t mul_full;

  // remainder unit
  logic            div_start;
  logic            div_done;
  mexp_pkg::prod_t div_dvd;
  mexp_pkg::word_t div_rem;

  logic in_beat;
  logic out_load;

  assign in_ready = (state == mexp_pkg::ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  // result register is free, or drains this cycle
  assign out_load = (state == mexp_pkg::ST_DONE) && (!out_valid || out_ready);

  // multiply is acc * sq or sq * sq
  assign mul_a    = (state == mexp_pkg::ST_MUL_ACC) ? acc : sq;
  assign mul_full = mexp_pkg::PROD_W'(mul_a) * mexp_pkg::PROD_W'(sq);

  // the base reduction feeds the bare base, everything else the product
  assign div_dvd = (state == mexp_pkg::ST_RED_B) ?
                   {{mexp_pkg::WORD_W{1'b0}}, b_r} : prod;

  mexp_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (mod_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // state register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mexp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          // zero modulus goes straight to the result
          state_next = (modulus == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_RED_B;
        end
      end
      mexp_pkg::ST_RED_B: begin
        div_start  = 1'b1;
        state_next = mexp_pkg::ST_WAIT_B;
      end
      mexp_pkg::ST_WAIT_B: begin
        if (div_done) begin
          state_next = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (exp_r == '0) begin
          state_next = mexp_pkg::ST_DONE;
        end else if (exp_r[0]) begin
          state_next = mexp_pkg::ST_MUL_ACC;
        end else begin
          state_next = mexp_pkg::ST_MUL_SQ;
        end
      end
      mexp_pkg::ST_MUL_ACC: begin
        state_next = mexp_pkg::ST_DIV_ACC;
      end
      mexp_pkg::ST_DIV_ACC: begin
        div_start  = 1'b1;
        state_next = mexp_pkg::ST_WAIT_ACC;
      end
      mexp_pkg::ST_WAIT_ACC: begin
        if (div_done) begin
          state_next = mexp_pkg::ST_MUL_SQ;
        end
      end
      mexp_pkg::ST_MUL_SQ: begin
        state_next = mexp_pkg::ST_DIV_SQ;
      end
      mexp_pkg::ST_DIV_SQ: begin
        div_start  = 1'b1;
        state_next = mexp_pkg::ST_WAIT_SQ;
      end
      mexp_pkg::ST_WAIT_SQ: begin
        if (div_done) begin
          state_next = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_beat) begin
      b_r   <= base_value;
      exp_r <= power;
      mod_r <= modulus;
      bad_r <= (modulus == '0);
      // 1 mod m, and 0 for the zero-modulus result
      acc   <= (modulus == 32'd1 || modulus == '0) ? '0 : 32'd1;
    end
    if (state == mexp_pkg::ST_WAIT_B && div_done) begin
      sq <= div_rem;
    end
    if (state == mexp_pkg::ST_MUL_ACC || state == mexp_pkg::ST_MUL_SQ) begin
      prod <= mul_full;
    end
    if (state == mexp_pkg::ST_WAIT_ACC && div_done) begin
      acc <= div_rem;
    end
    if (state == mexp_pkg::ST_WAIT_SQ && div_done) begin
      sq    <= div_rem;
      exp_r <= {1'b0, exp_r[mexp_pkg::WORD_W-1:1]};
    end
    if (out_load) begin
      residue     <= acc;
      bad_modulus <= bad_r;
    end
  end

  // a flagged result never carries a residue
  `MEXP_ASSERT_SAME(a_bad_zero, clk, rst, out_valid && bad_modulus, residue == '0,
                    "flagged result has nonzero residue")
  // running values stay reduced between exponent bits
  `MEXP_ASSERT_SAME(a_acc_reduced, clk, rst, state == mexp_pkg::ST_CHECK, acc < mod_r,
                    "running product not reduced")
  `MEXP_ASSERT_SAME(a_sq_reduced, clk, rst, state == mexp_pkg::ST_CHECK, sq < mod_r,
                    "running square not reduced")
  // the remainder unit only finishes while the sequencer waits on it
  `MEXP_ASSERT_SAME(a_done_wait, clk, rst, div_done,
                    state == mexp_pkg::ST_WAIT_B || state == mexp_pkg::ST_WAIT_ACC ||
                    state == mexp_pkg::ST_WAIT_SQ,
                    "remainder done outside a wait state")
  // a finished item hands over its result in the next cycle
  `MEXP_ASSERT_NEXT(a_load_valid, clk, rst, out_load, out_valid, "result load lost")

endmodule

// ----- tb/tb_modular_exponentiation_32.sv -----
`timescale 1ns / 1ps

// self-checking bench for the 32-bit square-and-multiply modular exponentiation
module tb_modular_exponentiation_32;

  // one directed stimulus row; typed rows carry their answer, the rest use the predictor
  typedef struct packed {
    mexp_pkg::word_t base_value;
    mexp_pkg::word_t power;
    mexp_pkg::word_t modulus;
    logic            typed;
    mexp_pkg::word_t residue;
    logic            bad_modulus;
  } stim_row_t;

  // one expected output beat
  typedef struct packed {
    mexp_pkg::word_t residue;
    logic            bad_modulus;
  } pow_result_t;

  localparam int unsigned DIRECTED_N   = 20;
  localparam int unsigned RANDOM_N     = 122;
  localparam int unsigned MAX_GAP      = 12;
  // receiver stops for this long once, so the output register and the core both fill
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned HOLD_CYCLES  = 15000;
  // drain margin, sized for a full 32-bit power with every bit set
  localparam int unsigned DRAIN_CYCLES = 5000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  mexp_pkg::word_t base_value = '0;
  mexp_pkg::word_t power = '0;
  mexp_pkg::word_t modulus = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  mexp_pkg::word_t residue;
  logic            bad_modulus;

  pow_result_t expected_q[$];
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned beats_sent   = 0;
  // calm stretches with no idling on either side
  bit          sender_calm  = 1'b0;
  bit          receiver_calm = 1'b0;

  // directed part: extremes, the zero-power, unit-modulus and zero-modulus cases
  stim_row_t directed_rows [DIRECTED_N] = '{
    // zero modulus flags and returns zero, no arithmetic
    '{32'd5,          32'd7,          32'd0,          1'b1, 32'd0,          1'b1},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0,          1'b1, 32'd0,          1'b1},
    '{32'd0,          32'd0,          32'd0,          1'b1, 32'd0,          1'b1},
    // zero power gives 1 mod modulus
    '{32'd12345,      32'd0,          32'd1,          1'b1, 32'd0,          1'b0},
    '{32'd12345,      32'd0,          32'd7,          1'b1, 32'd1,          1'b0},
    '{32'hFFFF_FFFF,  32'd0,          32'hFFFF_FFFF,  1'b1, 32'd1,          1'b0},
    '{32'd0,          32'd0,          32'd13,         1'b1, 32'd1,          1'b0},
    // unit modulus always gives zero
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd1,          1'b1, 32'd0,          1'b0},
    // zero base with a nonzero power, then further typed cases
    '{32'd0,          32'd5,          32'd13,         1'b1, 32'd0,          1'b0},
    '{32'd0,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0,          1'b0},
    '{32'd2,          32'd10,         32'd1000,       1'b1, 32'd24,         1'b0},
    '{32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd1,          1'b0},
    '{32'd12345,      32'd1,          32'd1000,       1'b1, 32'd345,        1'b0},
    '{32'd13,         32'd5,          32'd13,         1'b1, 32'd0,          1'b0},
    // the rest go through the predictor
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0},
    '{32'hFFFF_FFFE,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, 32'd0,          1'b0},
    '{32'd1000,       32'd3,          32'd7,          1'b0, 32'd0,          1'b0},
    '{32'd3,          32'h8000_0000,  32'hFFFF_FFFB,  1'b0, 32'd0,          1'b0},
    '{32'd2,          32'hFFFF_FFFF,  32'hFFFF_FFFB,  1'b0, 32'd0,          1'b0},
    '{32'hDEAD_BEEF,  32'h1234_5678,  32'h8000_0000,  1'b0, 32'd0,          1'b0}
  };

  modular_exponentiation_32 dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .base_value  (base_value),
    .power       (power),
    .modulus     (modulus),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .residue     (residue),
    .bad_modulus (bad_modulus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // right-to-left square-and-multiply, both operands kept below the modulus
  function automatic pow_result_t predict_pow(mexp_pkg::word_t b, mexp_pkg::word_t e,
                                              mexp_pkg::word_t m);
    pow_result_t r;
    bit [63:0]   acc;
    bit [63:0]   sq;
    bit [63:0]   m64;
    r.residue     = '0;
    r.bad_modulus = 1'b0;
    if (m == '0) begin
      r.bad_modulus = 1'b1;
      return r;
    end
    m64 = {32'd0, m};
    acc = (m == 32'd1) ? 64'd0 : 64'd1;
    sq  = {32'd0, b} % m64;
    for (int i = 0; i < mexp_pkg::WORD_W; i++) begin
      if (e[i]) acc = (acc * sq) % m64;
      sq = (sq * sq) % m64;
    end
    r.residue = acc[31:0];
    return r;
  endfunction

  // offer one input beat after a random gap; valid stays up until accepted
  task automatic send_beat(mexp_pkg::word_t b, mexp_pkg::word_t p, mexp_pkg::word_t m,
                           logic typed, pow_result_t typed_result);
    int unsigned gap;
    pow_result_t want;
    if (beats_sent % 16 == 0) sender_calm = ($urandom_range(0, 2) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    base_value <= b;
    power      <= p;
    modulus    <= m;
    do @(posedge clk); while (!in_ready);
    // beat taken at this edge
    want = typed ? typed_result : predict_pow(b, p, m);
    expected_q = {expected_q, want};
    beats_sent++;
  endtask

  // random item, weighted toward short powers so the run stays fast
  task automatic make_item(output mexp_pkg::word_t b, output mexp_pkg::word_t p,
                           output mexp_pkg::word_t m);
    int unsigned w;
    case ($urandom_range(0, 15))
      0:       m = 32'd0;
      1:       m = 32'd1;
      2:       m = 32'd2;
      3:       m = 32'hFFFF_FFFF;
      4:       m = 32'd1 << $urandom_range(1, 31);
      5, 6:    m = $urandom_range(2, 255);
      default: m = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       b = 32'd0;
      1:       b = 32'd1;
      2:       b = m - 32'd1;
      3:       b = 32'hFFFF_FFFF;
      4:       b = m;
      default: b = $urandom;
    endcase
    case ($urandom_range(0, 19))
      0:       p = 32'd0;
      1:       p = 32'd1;
      2:       p = 32'hFFFF_FFFF;
      3, 4:    p = $urandom;
      5, 6, 7, 8: begin
        w = $urandom_range(13, 20);
        p = $urandom & ((32'd1 << w) - 32'd1);
      end
      default: begin
        w = $urandom_range(1, 12);
        p = $urandom & ((32'd1 << w) - 32'd1);
      end
    endcase
  endtask

  // compare one output beat with the oldest expectation
  task automatic check_result(mexp_pkg::word_t got_residue, logic got_bad);
    pow_result_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      $error("unexpected output beat: residue %h bad_modulus %b", got_residue, got_bad);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got_residue !== want.residue) begin
      $error("residue mismatch: expected %h, got %h", want.residue, got_residue);
      fail_count++;
    end
    if (got_bad !== want.bad_modulus) begin
      $error("bad_modulus mismatch: expected %b, got %b", want.bad_modulus, got_bad);
      fail_count++;
    end
  endtask

  // sender side and end of run
  initial begin
    mexp_pkg::word_t b;
    mexp_pkg::word_t p;
    mexp_pkg::word_t m;
    pow_result_t     typed_result;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_N; i++) begin
      typed_result.residue     = directed_rows[i].residue;
      typed_result.bad_modulus = directed_rows[i].bad_modulus;
      send_beat(directed_rows[i].base_value, directed_rows[i].power,
                directed_rows[i].modulus, directed_rows[i].typed, typed_result);
    end

    // random items, all checked against the predictor
    typed_result = '0;
    for (int i = 0; i < RANDOM_N; i++) begin
      make_item(b, p, m);
      send_beat(b, p, m, 1'b0, typed_result);
    end
    in_valid <= 1'b0;

    // drain, then leave room for any stray beat
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("modular_exponentiation_32 test passed");
    end else begin
      $display("modular_exponentiation_32 test failed");
    end
    $finish;
  end

  // receiver side, with one long hold-off to back the block up
  initial begin
    int unsigned gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (results_seen % 16 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
      gap = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(residue, bad_modulus);
    end
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("modular_exponentiation_32 test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/mexp_pkg.sv
design/mexp_rem.sv
design/modular_exponentiation_32.sv
tb/tb_modular_exponentiation_32.sv
